FILE: sv/rms_pkg.sv
`default_nettype none

package rms_pkg;

    // Width of the value field on both stream ports.
    localparam int VALUE_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic pass_init;
        logic seg_init;
        logic merge_step;
        logic pass_next;
        logic emit_init;
        logic emit_capture;
        logic emit_next;
        logic batch_clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seg_end;
        logic pass_end;
        logic sort_done;
        logic emit_last;
    } t_status;

endpackage

`default_nettype wire

FILE: sv/rms_datapath.sv
`default_nettype none

module rms_datapath #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rms_pkg::t_cmd               i_cmd,
    input  wire logic [rms_pkg::VALUE_W-1:0] i_value,
    output rms_pkg::t_status                 o_status,
    output logic      [rms_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                             o_last_out,
    output logic                             o_overflow
);
    import rms_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 3;
    localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

    // Two banks: each merge pass reads one and writes the other.
    logic [DATA_WIDTH-1:0] bank0 [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] bank1 [MAX_ITEMS];

    logic [DATA_WIDTH-1:0] r_rd0a, r_rd0b, r_rd1a, r_rd1b;
    logic [DATA_WIDTH-1:0] r_out_data;
    logic                  r_out_last, r_out_ovf;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_src, n_src;
    logic [WW-1:0] r_w, n_w;
    logic [CW-1:0] r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [CW-1:0] r_ia, n_ia, r_ib, n_ib, r_k, n_k;

    logic [DATA_WIDTH-1:0] in_val, rd_a, rd_b, wr_data;
    logic [AW-1:0]         wr_addr;
    logic                  we0, we1;
    logic                  a_ok, b_ok, take_a;
    logic [SW-1:0]         sum_mid, sum_hi;

    assign in_val = DATA_WIDTH'($signed(i_value));

    // Read words of the current source bank.
    assign rd_a = r_src ? r_rd1a : r_rd0a;
    assign rd_b = r_src ? r_rd1b : r_rd0b;

    // Merge decision: take the left head while it is not above the right one.
    assign a_ok   = (r_ia != r_mid);
    assign b_ok   = (r_ib != r_hi);
    assign take_a = a_ok && (!b_ok || ($signed(rd_a) <= $signed(rd_b)));

    assign sum_mid = SW'(r_lo) + SW'(r_w);
    assign sum_hi  = SW'(r_lo) + (SW'(r_w) << 1);

    // Status toward the controller.
    assign o_status.seg_end   = (SW'(r_k) + SW'(1) == SW'(r_hi));
    assign o_status.pass_end  = (r_hi == r_count);
    assign o_status.sort_done = (r_w >= WW'(r_count));
    assign o_status.emit_last = (SW'(r_ia) + SW'(1) == SW'(r_count));

    // Write port selection: loading fills bank 0, merging fills the other bank.
    always_comb begin
        we0     = 1'b0;
        we1     = 1'b0;
        wr_addr = r_k[AW-1:0];
        wr_data = take_a ? rd_a : rd_b;
        if (i_cmd.load_we && (r_count < CAP)) begin
            we0     = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = in_val;
        end else if (i_cmd.merge_step) begin
            we0 = r_src;
            we1 = !r_src;
        end
    end

    // Next values of counters and pointers.
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_src   = r_src;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_ia    = r_ia;
        n_ib    = r_ib;
        n_k     = r_k;
        if (i_cmd.load_we) begin
            if (r_count < CAP) begin
                n_count = r_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.pass_init) begin
            n_w   = WW'(1);
            n_lo  = '0;
            n_src = 1'b0;
        end
        if (i_cmd.seg_init) begin
            n_mid = (sum_mid < SW'(r_count)) ? CW'(sum_mid) : r_count;
            n_hi  = (sum_hi < SW'(r_count)) ? CW'(sum_hi) : r_count;
            n_ia  = r_lo;
            n_ib  = n_mid;
            n_k   = r_lo;
        end
        if (i_cmd.merge_step) begin
            n_ia = r_ia + CW'(take_a);
            n_ib = r_ib + CW'(!take_a);
            n_k  = r_k + CW'(1);
            if (o_status.seg_end) begin
                n_lo = r_hi;
            end
        end
        if (i_cmd.pass_next) begin
            n_w   = r_w << 1;
            n_lo  = '0;
            n_src = !r_src;
        end
        if (i_cmd.emit_init) begin
            n_ia = '0;
        end
        if (i_cmd.emit_next) begin
            n_ia = r_ia + CW'(1);
        end
        if (i_cmd.batch_clear) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    // Batch bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_src   <= n_src;
        end
    end

    // Merge pointers and output word.
    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_ia  <= n_ia;
        r_ib  <= n_ib;
        r_k   <= n_k;
        if (i_cmd.emit_capture) begin
            r_out_data <= rd_a;
            r_out_last <= o_status.emit_last;
            r_out_ovf  <= r_ovf;
        end
    end

    // Bank 0: one write port, two registered read ports at the next pointers.
    always_ff @(posedge i_clk) begin
        if (we0) begin
            bank0[wr_addr] <= wr_data;
        end
        r_rd0a <= bank0[n_ia[AW-1:0]];
        r_rd0b <= bank0[n_ib[AW-1:0]];
    end

    // Bank 1: same organization.
    always_ff @(posedge i_clk) begin
        if (we1) begin
            bank1[wr_addr] <= wr_data;
        end
        r_rd1a <= bank1[n_ia[AW-1:0]];
        r_rd1b <= bank1[n_ib[AW-1:0]];
    end

    assign o_sorted_value = VALUE_W'($signed(r_out_data));
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

`default_nettype wire

FILE: sv/rms_ctrl.sv
`default_nettype none

module rms_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_s_tlast,
    input  wire logic             i_m_tready,
    input  wire rms_pkg::t_status i_status,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    output rms_pkg::t_cmd         o_cmd
);
    import rms_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CHECK,
        S_MERGE,
        S_TURN,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = r_m_valid;

    // Sequencing of load, merge passes and emission.
    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        case (r_state)
            S_LOAD: begin
                if (i_s_tvalid) begin
                    o_cmd.load_we = 1'b1;
                    if (i_s_tlast) begin
                        o_cmd.pass_init = 1'b1;
                        n_state         = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.sort_done) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT_LD;
                end else begin
                    o_cmd.seg_init = 1'b1;
                    n_state        = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.merge_step = 1'b1;
                if (i_status.seg_end) begin
                    n_state = i_status.pass_end ? S_TURN : S_CHECK;
                end
            end
            S_TURN: begin
                o_cmd.pass_next = 1'b1;
                n_state         = S_CHECK;
            end
            S_EMIT_LD: begin
                o_cmd.emit_capture = 1'b1;
                n_m_valid          = 1'b1;
                n_state            = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_m_tready) begin
                    n_m_valid = 1'b0;
                    if (i_status.emit_last) begin
                        o_cmd.batch_clear = 1'b1;
                        n_state           = S_LOAD;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = S_EMIT_LD;
                    end
                end
            end
            default: begin
                n_state   = S_LOAD;
                n_m_valid = 1'b0;
            end
        endcase
    end

    // State and output valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

`default_nettype wire

FILE: sv/run_merge_sorter_unit.sv
// Channel  | Direction | Handshake               | Payload
// s        | in        | i_s_tvalid / o_s_tready | i_s_tdata = value, i_s_tlast = last_in
// m        | out       | o_m_tvalid / i_m_tready | o_m_tdata = sorted_value,
//          |           |                         | o_m_tlast = last_out, o_m_tuser = overflow
//
// A batch of N words is loaded at one word per cycle, then sorted by
// bottom-up merge passes over two ping-pong banks: each run pair is set up
// and then merged, and each pass ends with a bank turn; ceil(log2(N)) passes in all.
// Emission captures each word (S_EMIT_LD) and holds it (S_EMIT_WAIT) until the sink takes it.
// No input is taken from the end of a batch until its last word is delivered.
// Reset (i_rst_n low, synchronous) empties the batch; the banks are not cleared.
`default_nettype none

module run_merge_sorter_unit #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [rms_pkg::VALUE_W-1:0] i_s_tdata,  // [31:0] value
    input  wire logic                        i_s_tlast,  // last_in
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic      [rms_pkg::VALUE_W-1:0] o_m_tdata,  // [31:0] sorted_value
    output logic                             o_m_tlast,  // last_out
    output logic                             o_m_tuser   // [0] overflow
);
    import rms_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    rms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    // Banks, merge pointers and output word.
    rms_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_s_tdata),
        .o_status       (status),
        .o_sorted_value (o_m_tdata),
        .o_last_out     (o_m_tlast),
        .o_overflow     (o_m_tuser)
    );

endmodule

`default_nettype wire

FILE: sv/rms_checker.sv
`default_nettype none

module rms_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        i_s_tlast,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tlast,
    input wire logic        o_m_tuser
);

    // The block never takes input while a sorted word is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while output valid");

    // The end of a batch closes the input until the batch is emitted.
    a_close_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input still open after batch end");

    // Delivering the last sorted word reopens the input at once.
    a_open_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("input not reopened after batch emitted");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled output word changed");

endmodule

bind run_merge_sorter_unit rms_checker u_rms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
